@@ sv/avt_pkg.sv @@
// avt_pkg: shared types, constants and helpers of the affine vertex transform
// no dependencies; imported by every module of the block

package avt_pkg;

	localparam int REG_COUNT = 6;
	localparam int COORD_W   = 32;
	localparam int SUM_W     = 66;

	// opcodes of an input item
	typedef enum logic [1:0] {
		OP_POINT = 2'd0,
		OP_DIR   = 2'd1,
		OP_PROJ  = 2'd2,
		OP_RSVD  = 2'd3
	} avt_op_t;

	typedef logic signed [COORD_W-1:0] coord_t;

	// coefficient register reset values (identity for 16 fraction bits)
	localparam logic [63:0] COEF_RESET [REG_COUNT] = '{
		64'd65536, 64'd0, 64'd65536, 64'd0, 64'd65536, 64'd0
	};

	// control bits that travel down the pipeline with each item
	typedef struct packed {
		logic valid;
		logic proj;
		logic sat;
		logic dz;
	} avt_ctl_t;

	typedef struct packed {
		coord_t val;
		logic   clip;
	} sat_t;

	// clip a wide signed sum to the signed 32-bit range
	function automatic sat_t sat_coord(input logic signed [SUM_W-1:0] v);
		sat_t r;
		if (v > 66'sd2147483647) begin
			r.val  = 32'sh7FFFFFFF;
			r.clip = 1'b1;
		end else if (v < -66'sd2147483648) begin
			r.val  = 32'sh80000000;
			r.clip = 1'b1;
		end else begin
			r.val  = v[COORD_W-1:0];
			r.clip = 1'b0;
		end
		return r;
	endfunction

endpackage

@@ sv/avt_in_if.sv @@
// avt_in_if: input channel of the affine vertex transform
// carries one vertex item with its opcode; no dependencies

interface avt_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic signed [31:0] x_in;
	logic signed [31:0] y_in;
	logic signed [31:0] z_in;

	modport source (output valid, opcode, x_in, y_in, z_in, input ready);
	modport sink (input valid, opcode, x_in, y_in, z_in, output ready);
endinterface

@@ sv/avt_out_if.sv @@
// avt_out_if: result channel of the affine vertex transform
// carries one transformed vertex with its flags; no dependencies

interface avt_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] x_out;
	logic signed [31:0] y_out;
	logic signed [31:0] z_out;
	logic               saturated;
	logic               divide_by_zero;

	modport source (output valid, x_out, y_out, z_out, saturated, divide_by_zero,
		input ready);
	modport sink (input valid, x_out, y_out, z_out, saturated, divide_by_zero,
		output ready);
endinterface

@@ sv/avt_dot.sv @@
// avt_dot: three-stage matrix-vector unit (multiply, sum, floor and clip)
// depends on avt_pkg

module avt_dot import avt_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [1:0]  opcode,
	input  coord_t      x_in,
	input  coord_t      y_in,
	input  coord_t      z_in,
	input  logic [63:0] coef [REG_COUNT],
	output avt_ctl_t    ctl_s3,
	output coord_t      res_s3 [3]
);

	coord_t m [2*REG_COUNT];
	coord_t vec [3];

	logic signed [63:0]      prod_s1 [3][3];
	coord_t                  tr_s1 [3];
	avt_ctl_t                ctl_s1;
	logic signed [SUM_W-1:0] sum_s2 [3];
	avt_ctl_t                ctl_s2;

	sat_t                    clip [3];
	logic signed [SUM_W-1:0] flo [3];

	// unpack coefficients, two per register
	always_comb begin
		for (int i = 0; i < REG_COUNT; i++) begin
			m[2*i]   = coef[i][31:0];
			m[2*i+1] = coef[i][63:32];
		end
		vec[0] = x_in;
		vec[1] = y_in;
		vec[2] = z_in;
	end

	// stage 1: nine products and the translation row
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s1[c][k] <= vec[k] * m[3*k+c];
				end
				tr_s1[c] <= (opcode == OP_DIR) ? '0 : m[9+c];
			end
		end
	end

	// stage 2: exact sum per output column
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				sum_s2[c] <= SUM_W'(prod_s1[c][0]) + SUM_W'(prod_s1[c][1])
					+ SUM_W'(prod_s1[c][2]) + (SUM_W'(tr_s1[c]) <<< FRAC_BITS);
			end
		end
	end

	// floor to the fixed-point grid and clip
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			flo[c]  = sum_s2[c] >>> FRAC_BITS;
			clip[c] = sat_coord(flo[c]);
		end
	end

	// stage 3 result registers
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				res_s3[c] <= clip[c].val;
			end
		end
	end

	// control bits per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s1.valid <= in_valid;
			ctl_s1.proj  <= (opcode == OP_PROJ);
			ctl_s1.sat   <= 1'b0;
			ctl_s1.dz    <= 1'b0;
			ctl_s2       <= ctl_s1;
			ctl_s3.valid <= ctl_s2.valid;
			ctl_s3.proj  <= ctl_s2.proj;
			ctl_s3.sat   <= clip[0].clip | clip[1].clip | clip[2].clip;
			ctl_s3.dz    <= ctl_s2.proj && (clip[2].val == '0);
		end
	end

	// a zero-divisor item must be a projection with a zero z
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s3.valid && ctl_s3.dz) |-> (res_s3[2] == '0 && ctl_s3.proj))
		else $error("zero divisor flag without zero z");

endmodule

@@ sv/avt_div.sv @@
// avt_div: pipelined restoring divider, one quotient bit per stage, two lanes
// divides x and y (scaled by the fraction) by z; depends on avt_pkg

module avt_div import avt_pkg::*; #(
	parameter int FRAC_BITS = 16,
	localparam int QW = COORD_W + FRAC_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  avt_ctl_t      ctl_in,
	input  coord_t        res_in [3],
	output avt_ctl_t      ctl_out,
	output coord_t        res_out [3],
	output logic [QW-1:0] qx,
	output logic [QW-1:0] qy,
	output logic          neg_x,
	output logic          neg_y
);

	avt_ctl_t      ctl_p [QW+1];
	coord_t        res_p [QW+1][3];
	logic [31:0]   rem_x [QW+1];
	logic [31:0]   rem_y [QW+1];
	logic [QW-1:0] nq_x [QW+1];
	logic [QW-1:0] nq_y [QW+1];
	logic [31:0]   den_p [QW+1];
	logic          nx_p [QW+1];
	logic          ny_p [QW+1];

	logic [31:0]   abs_x;
	logic [31:0]   abs_y;
	logic [31:0]   abs_z;

	// one restoring step: shift in a dividend bit, subtract if it fits
	function automatic logic [32+QW-1:0] div_step(input logic [31:0] rem,
		input logic [QW-1:0] nq, input logic [31:0] d);
		logic [32:0] r2;
		logic [32:0] diff;
		logic        b;
		r2   = {rem, nq[QW-1]};
		diff = r2 - {1'b0, d};
		b    = !diff[32];
		return {(b ? diff[31:0] : r2[31:0]), nq[QW-2:0], b};
	endfunction

	// magnitudes of the operands
	always_comb begin
		abs_x = res_in[0][31] ? 32'(-res_in[0]) : 32'(res_in[0]);
		abs_y = res_in[1][31] ? 32'(-res_in[1]) : 32'(res_in[1]);
		abs_z = res_in[2][31] ? 32'(-res_in[2]) : 32'(res_in[2]);
	end

	// setup stage: load scaled dividends
	always_ff @(posedge clk) begin
		if (en) begin
			res_p[0] <= res_in;
			rem_x[0] <= '0;
			rem_y[0] <= '0;
			nq_x[0]  <= {abs_x, {FRAC_BITS{1'b0}}};
			nq_y[0]  <= {abs_y, {FRAC_BITS{1'b0}}};
			den_p[0] <= abs_z;
			nx_p[0]  <= res_in[0][31] ^ res_in[2][31];
			ny_p[0]  <= res_in[1][31] ^ res_in[2][31];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_p[0] <= '0;
		end else if (en) begin
			ctl_p[0] <= ctl_in;
		end
	end

	// quotient stages
	for (genvar j = 0; j < QW; j++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				{rem_x[j+1], nq_x[j+1]} <= div_step(rem_x[j], nq_x[j], den_p[j]);
				{rem_y[j+1], nq_y[j+1]} <= div_step(rem_y[j], nq_y[j], den_p[j]);
				den_p[j+1] <= den_p[j];
				res_p[j+1] <= res_p[j];
				nx_p[j+1]  <= nx_p[j];
				ny_p[j+1]  <= ny_p[j];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_p[j+1] <= '0;
			end else if (en) begin
				ctl_p[j+1] <= ctl_p[j];
			end
		end
	end

	assign ctl_out = ctl_p[QW];
	assign res_out = res_p[QW];
	assign qx      = nq_x[QW];
	assign qy      = nq_y[QW];
	assign neg_x   = nx_p[QW];
	assign neg_y   = ny_p[QW];

endmodule

@@ sv/affine_vertex_transform.sv @@
// affine_vertex_transform: top level, coefficient registers, pipeline and result register
// depends on avt_pkg, avt_in_if, avt_out_if, avt_dot, avt_div
//
//   channel   | kind          | carries
//   ----------+---------------+------------------------------------------
//   vertex    | valid/ready   | opcode, x_in, y_in, z_in
//   result    | valid/ready   | x_out, y_out, z_out, saturated, divide_by_zero
//   apb       | psel/penable  | six 64-bit coefficient registers at 8*i
//
// One item enters per cycle while the pipeline advances; the stages are
// three stages of matrix product, one divider setup stage, one stage per
// quotient bit of the 32 + FRAC_BITS bit divider, and the result register.
// All stages advance together whenever the result register is empty or taken;
// while it is full and not taken the whole pipeline holds.
// Reset clears all valid bits and loads the identity matrix.

module affine_vertex_transform import avt_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	avt_in_if.sink      vertex,
	avt_out_if.source   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	localparam int QW = COORD_W + FRAC_BITS;
	localparam logic [31:0] ONE_FX = 32'd1 << FRAC_BITS;

	logic [63:0]   coef_q [REG_COUNT];
	logic [2:0]    reg_idx;
	logic          reg_wr;
	logic          en;

	avt_ctl_t      ctl_s3;
	coord_t        res_s3 [3];
	avt_ctl_t      ctl_d;
	coord_t        res_d [3];
	logic [QW-1:0] qx;
	logic [QW-1:0] qy;
	logic          neg_x;
	logic          neg_y;

	sat_t          dx;
	sat_t          dy;
	coord_t        x_n;
	coord_t        y_n;
	coord_t        z_n;
	logic          sat_n;
	logic          dz_n;

	logic          out_valid_q;
	coord_t        x_q;
	coord_t        y_q;
	coord_t        z_q;
	logic          sat_q;
	logic          dz_q;

	// signed quotient from magnitude, clipped to 32 bits
	function automatic sat_t fix_quot(input logic [QW-1:0] q, input logic neg);
		sat_t r;
		if (!neg) begin
			if (|q[QW-1:31]) begin
				r.val  = 32'sh7FFFFFFF;
				r.clip = 1'b1;
			end else begin
				r.val  = q[31:0];
				r.clip = 1'b0;
			end
		end else begin
			if ((|q[QW-1:32]) || (q[31] && (|q[30:0]))) begin
				r.val  = 32'sh80000000;
				r.clip = 1'b1;
			end else begin
				r.val  = -q[31:0];
				r.clip = 1'b0;
			end
		end
		return r;
	endfunction

	// coefficient registers
	assign reg_idx = paddr[5:3];
	assign reg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				coef_q[i] <= COEF_RESET[i];
			end
		end else if (reg_wr && (reg_idx < 3'(REG_COUNT))) begin
			coef_q[reg_idx] <= pwdata;
		end
	end

	assign prdata = (reg_idx < 3'(REG_COUNT)) ? coef_q[reg_idx] : '0;

	// global advance
	assign en           = !out_valid_q || result.ready;
	assign vertex.ready = en;

	avt_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vertex.valid),
		.opcode   (vertex.opcode),
		.x_in     (vertex.x_in),
		.y_in     (vertex.y_in),
		.z_in     (vertex.z_in),
		.coef     (coef_q),
		.ctl_s3   (ctl_s3),
		.res_s3   (res_s3)
	);

	avt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (ctl_s3),
		.res_in  (res_s3),
		.ctl_out (ctl_d),
		.res_out (res_d),
		.qx      (qx),
		.qy      (qy),
		.neg_x   (neg_x),
		.neg_y   (neg_y)
	);

	// final selection of the result item
	always_comb begin
		dx    = fix_quot(qx, neg_x);
		dy    = fix_quot(qy, neg_y);
		x_n   = res_d[0];
		y_n   = res_d[1];
		z_n   = res_d[2];
		sat_n = ctl_d.sat;
		dz_n  = 1'b0;
		if (ctl_d.proj) begin
			if (ctl_d.dz) begin
				x_n  = '0;
				y_n  = '0;
				z_n  = '0;
				dz_n = 1'b1;
			end else begin
				x_n   = dx.val;
				y_n   = dy.val;
				z_n   = ONE_FX;
				sat_n = ctl_d.sat | dx.clip | dy.clip;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctl_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q   <= x_n;
			y_q   <= y_n;
			z_q   <= z_n;
			sat_q <= sat_n;
			dz_q  <= dz_n;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.x_out          = x_q;
	assign result.y_out          = y_q;
	assign result.z_out          = z_q;
	assign result.saturated      = sat_q;
	assign result.divide_by_zero = dz_q;

	// the input side follows the result register state
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		vertex.ready == (!result.valid || result.ready))
		else $error("input ready does not follow result register");

	// a zero divisor yields an all-zero vertex
	a_dz_out: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.divide_by_zero) |->
			(result.x_out == '0 && result.y_out == '0 && result.z_out == '0))
		else $error("zero divisor item with nonzero coordinates");

endmodule
